[rtl/cus_pkg.sv]
package cus_pkg;

	localparam int unsigned MAX_URI_BYTES = 1024;
	localparam int unsigned POS_W = $clog2(MAX_URI_BYTES + 1);
	localparam int unsigned OFF_W = 10;
	localparam int unsigned LEN_W = 11;
	localparam int unsigned PORT_W = 16;
	localparam int unsigned ACC_W = 17;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned OUT_TDATA_W = 88;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEFAULT_PORT = 1'd0,
		REG_SECURE_DEFAULT_PORT = 1'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SCHEME  = 3'd1,
		ST_SEP     = 3'd2,
		ST_HOST    = 3'd3,
		ST_RANGE   = 3'd4,
		ST_TRAIL   = 3'd5,
		ST_TOOLONG = 3'd6
	} status_t;

	// status sits in the lowest bits, so the struct packs straight into tdata
	typedef struct packed {
		logic [LEN_W-1:0]  query_length;
		logic [OFF_W-1:0]  query_offset;
		logic [LEN_W-1:0]  path_length;
		logic [OFF_W-1:0]  path_offset;
		logic [LEN_W-1:0]  host_length;
		logic [OFF_W-1:0]  host_offset;
		logic [PORT_W-1:0] port;
		logic              secure;
		status_t           status;
	} result_t;

	localparam int unsigned RES_W = $bits(result_t);

	function automatic logic [7:0] scheme_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = "c";
			3'd1: ch = "o";
			3'd2: ch = "a";
			3'd3: ch = "p";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] sep_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = ":";
			3'd1: ch = "/";
			3'd2: ch = "/";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

[rtl/cus_in_reg.sv]
module cus_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] uri_byte
	input  logic       s_tlast,   // last_byte
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       last_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

endmodule

[rtl/cus_parser.sv]
module cus_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [7:0]                 uri_byte,
	input  logic                       last_byte,
	input  logic [cus_pkg::PORT_W-1:0] default_port,
	input  logic [cus_pkg::PORT_W-1:0] secure_default_port,
	output logic                       res_valid,
	output cus_pkg::result_t           res
);
	import cus_pkg::*;

	typedef enum logic [3:0] {
		PH_START, PH_SCHEME, PH_SOPT, PH_SEP, PH_HOSTFIRST, PH_HOST,
		PH_BRACKET, PH_AFTERHOST, PH_PORT, PH_PATH, PH_QUERY
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic [2:0]       idx;
		logic [POS_W-1:0] pos;
		logic [ACC_W-1:0] acc;
		logic             secure;
		status_t          err;
		logic [OFF_W-1:0] host_start;
		logic [LEN_W-1:0] host_count;
		logic [OFF_W-1:0] path_start;
		logic [LEN_W-1:0] path_count;
		logic [OFF_W-1:0] query_start;
		logic [LEN_W-1:0] query_count;
		logic             port_seen;
	} pstate_t;

	localparam pstate_t PSTATE_CLR = '{
		phase: PH_START, idx: '0, pos: '0, acc: '0, secure: 1'b0, err: ST_OK,
		host_start: '0, host_count: '0, path_start: '0, path_count: '0,
		query_start: '0, query_count: '0, port_seen: 1'b0
	};

	pstate_t st_q;
	pstate_t nx;
	logic [7:0] lc;
	logic [OFF_W-1:0] pos_p1;
	logic [20:0] acc_x10;
	logic is_delim;
	status_t fin;
	logic [PORT_W-1:0] port_sel;

	assign lc = (uri_byte >= "A" && uri_byte <= "Z") ? uri_byte + 8'd32 : uri_byte;
	assign pos_p1 = st_q.pos[OFF_W-1:0] + OFF_W'(1);
	assign is_delim = (uri_byte == ":") || (uri_byte == "/") || (uri_byte == "?");
	assign acc_x10 = {st_q.acc, 3'b000} + {2'b00, st_q.acc, 1'b0}
		+ 21'(uri_byte - "0");

	always_comb begin
		nx = st_q;
		if (st_q.pos >= POS_W'(MAX_URI_BYTES)) begin
			nx.err = ST_TOOLONG;
		end else begin
			nx.pos = st_q.pos + POS_W'(1);
			if (st_q.err == ST_OK) begin
				unique case (st_q.phase)
					PH_START: begin
						if (uri_byte == "/") begin
							nx.phase = PH_PATH;
							nx.path_start = pos_p1;
							nx.path_count = '0;
						end else if (lc == scheme_char(3'd0)) begin
							nx.phase = PH_SCHEME;
							nx.idx = 3'd1;
						end else begin
							nx.phase = PH_SCHEME;
							nx.idx = 3'd0;
							nx.err = ST_SCHEME;
						end
					end
					PH_SCHEME: begin
						if (st_q.idx < 3'd4 && lc == scheme_char(st_q.idx)) begin
							if (st_q.idx == 3'd3) begin
								nx.phase = PH_SOPT;
								nx.idx = 3'd0;
							end else begin
								nx.idx = st_q.idx + 3'd1;
							end
						end else begin
							nx.err = ST_SCHEME;
						end
					end
					PH_SOPT: begin
						nx.phase = PH_SEP;
						nx.idx = 3'd0;
						if (uri_byte == "s") begin
							nx.secure = 1'b1;
						end else if (uri_byte == sep_char(3'd0)) begin
							nx.idx = 3'd1;
						end else begin
							nx.err = ST_SEP;
						end
					end
					PH_SEP: begin
						if (st_q.idx < 3'd3 && uri_byte == sep_char(st_q.idx)) begin
							nx.idx = st_q.idx + 3'd1;
							if (st_q.idx == 3'd2) begin
								nx.phase = PH_HOSTFIRST;
							end
						end else begin
							nx.err = ST_SEP;
						end
					end
					PH_HOSTFIRST: begin
						if (uri_byte == "[") begin
							nx.phase = PH_BRACKET;
							nx.host_start = pos_p1;
							nx.host_count = '0;
						end else if (is_delim) begin
							nx.err = ST_HOST;
						end else begin
							nx.phase = PH_HOST;
							nx.host_start = st_q.pos[OFF_W-1:0];
							nx.host_count = LEN_W'(1);
						end
					end
					PH_BRACKET: begin
						if (uri_byte == "]") begin
							if (st_q.host_count == '0) begin
								nx.err = ST_HOST;
							end else begin
								nx.phase = PH_AFTERHOST;
							end
						end else begin
							nx.host_count = st_q.host_count + LEN_W'(1);
						end
					end
					PH_HOST, PH_AFTERHOST: begin
						priority if (uri_byte == ":") begin
							nx.phase = PH_PORT;
							nx.acc = '0;
							nx.port_seen = 1'b0;
						end else if (uri_byte == "/") begin
							nx.phase = PH_PATH;
							nx.path_start = pos_p1;
							nx.path_count = '0;
						end else if (uri_byte == "?") begin
							nx.phase = PH_QUERY;
							nx.query_start = pos_p1;
							nx.query_count = '0;
						end else if (st_q.phase == PH_HOST) begin
							nx.host_count = st_q.host_count + LEN_W'(1);
						end else begin
							nx.err = ST_TRAIL;
						end
					end
					PH_PORT: begin
						priority if (uri_byte >= "0" && uri_byte <= "9") begin
							// saturate so a long digit run still reads as out of range
							nx.acc = (acc_x10 > 21'd65536) ? ACC_W'(65536) : acc_x10[ACC_W-1:0];
							nx.port_seen = 1'b1;
						end else if (st_q.acc > ACC_W'(65535)) begin
							nx.err = ST_RANGE;
						end else if (uri_byte == "/") begin
							nx.phase = PH_PATH;
							nx.path_start = pos_p1;
							nx.path_count = '0;
						end else if (uri_byte == "?") begin
							nx.phase = PH_QUERY;
							nx.query_start = pos_p1;
							nx.query_count = '0;
						end else begin
							nx.err = ST_TRAIL;
						end
					end
					PH_PATH: begin
						if (uri_byte == "?") begin
							nx.phase = PH_QUERY;
							nx.query_start = pos_p1;
							nx.query_count = '0;
						end else begin
							nx.path_count = st_q.path_count + LEN_W'(1);
						end
					end
					PH_QUERY: begin
						nx.query_count = st_q.query_count + LEN_W'(1);
					end
					default: begin
						nx.err = ST_SCHEME;
					end
				endcase
			end
		end
	end

	always_comb begin
		if (nx.err != ST_OK) begin
			fin = nx.err;
		end else begin
			unique case (nx.phase)
				PH_START, PH_SCHEME: fin = ST_SCHEME;
				PH_SOPT, PH_SEP: fin = ST_SEP;
				PH_HOSTFIRST, PH_BRACKET: fin = ST_HOST;
				PH_PORT: fin = (nx.acc > ACC_W'(65535)) ? ST_RANGE : ST_OK;
				default: fin = ST_OK;
			endcase
		end
	end

	assign port_sel = nx.port_seen ? nx.acc[PORT_W-1:0]
		: (nx.secure ? secure_default_port : default_port);

	always_comb begin
		res = '0;
		res.status = fin;
		if (fin == ST_OK) begin
			res.secure = nx.secure;
			res.port = port_sel;
			if (nx.host_count != '0) begin
				res.host_offset = nx.host_start;
				res.host_length = nx.host_count;
			end
			if (nx.path_count != '0) begin
				res.path_offset = nx.path_start;
				res.path_length = nx.path_count;
			end
			if (nx.query_count != '0) begin
				res.query_offset = nx.query_start;
				res.query_length = nx.query_count;
			end
		end
	end

	assign res_valid = step && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PSTATE_CLR;
		end else if (step) begin
			// start over after the last byte of a URI
			st_q <= last_byte ? PSTATE_CLR : nx;
		end
	end

endmodule

[rtl/cus_out_reg.sv]
module cus_out_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  cus_pkg::result_t                res,
	output logic                            free,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cus_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import cus_pkg::*;

	result_t res_q;

	assign free = !m_tvalid || m_tready;
	assign m_tdata = {(OUT_TDATA_W - RES_W)'(0), res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (free) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

endmodule

[rtl/coap_uri_splitter.sv]
// channel  | direction | beat content
// s_*      | in        | tdata[7:0] uri_byte, tlast last_byte
// m_*      | out       | tdata: one parse result per URI (status ... query_length)
// cfg_*    | in        | cfg_index selects default_port / secure_default_port
//
// One byte per cycle while no last byte is held: each accepted byte lands in
// an input register and is parsed from there by the phase logic; the result of
// a URI is loaded into the output register on its last byte. A stalled result
// holds only the last byte of the following URI; other bytes keep flowing.
// Reset clears the parse state and sets the default ports to 5683 and 5684.
module coap_uri_splitter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] uri_byte
	input  logic                            s_tlast,   // last_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [2:0] status, [3] secure, [19:4] port, [29:20] host_offset,
	// [40:30] host_length, [50:41] path_offset, [61:51] path_length,
	// [71:62] query_offset, [82:72] query_length, [87:83] zero
	output logic [cus_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cus_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cus_pkg::PORT_W-1:0]      cfg_data
);
	import cus_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              advance;
	logic              free;
	logic              res_valid;
	result_t           res;
	logic [PORT_W-1:0] default_port_q;
	logic [PORT_W-1:0] secure_default_port_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_port_q <= PORT_W'(5683);
			secure_default_port_q <= PORT_W'(5684);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEFAULT_PORT: default_port_q <= cfg_data;
				REG_SECURE_DEFAULT_PORT: secure_default_port_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold a last byte while the previous result is still waiting
	assign advance = valid_s1 && (!last_s1 || free);

	cus_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	cus_parser u_parser (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (advance),
		.uri_byte            (byte_s1),
		.last_byte           (last_s1),
		.default_port        (default_port_q),
		.secure_default_port (secure_default_port_q),
		.res_valid           (res_valid),
		.res                 (res)
	);

	cus_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[dv/coap_uri_splitter_tb.sv]
module coap_uri_splitter_tb;
	import cus_pkg::*;

	typedef enum logic [3:0] {
		PH_START, PH_SCHEME, PH_SOPT, PH_SEP, PH_HOSTFIRST, PH_HOST,
		PH_BRACKET, PH_AFTERHOST, PH_PORT, PH_PATH, PH_QUERY
	} split_phase_t;

	class uri_split_board;
		logic [PORT_W-1:0] plain_port;
		logic [PORT_W-1:0] secure_port;
		split_phase_t      phase;
		int unsigned       idx, pos, acc;
		bit                sec, seen;
		status_t           err;
		int unsigned       h_start, h_cnt, p_start, p_cnt, q_start, q_cnt;
		result_t           split_due[$];
		int unsigned       errors, bytes, uris, checked;

		function new();
			plain_port = 16'd5683;
			secure_port = 16'd5684;
			errors = 0;
			bytes = 0;
			uris = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			phase = PH_START;
			idx = 0;
			pos = 0;
			acc = 0;
			sec = 0;
			seen = 0;
			err = ST_OK;
			h_start = 0;
			h_cnt = 0;
			p_start = 0;
			p_cnt = 0;
			q_start = 0;
			q_cnt = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [PORT_W-1:0] v);
			case (r)
				REG_DEFAULT_PORT: plain_port = v;
				REG_SECURE_DEFAULT_PORT: secure_port = v;
				default: ;
			endcase
		endfunction

		function void open_path(int unsigned at);
			phase = PH_PATH;
			p_start = at + 1;
			p_cnt = 0;
		endfunction

		function void open_query(int unsigned at);
			phase = PH_QUERY;
			q_start = at + 1;
			q_cnt = 0;
		endfunction

		function void match_sep(logic [7:0] c);
			string sep_txt;
			sep_txt = "://";
			if (idx < 3 && c == sep_txt[idx]) begin
				idx++;
				if (idx == 3)
					phase = PH_HOSTFIRST;
			end else begin
				err = ST_SEP;
			end
		endfunction

		function void after_host(logic [7:0] c, int unsigned at);
			if (c == ":") begin
				phase = PH_PORT;
				acc = 0;
				seen = 0;
			end else if (c == "/") begin
				open_path(at);
			end else if (c == "?") begin
				open_query(at);
			end else begin
				err = ST_TRAIL;
			end
		endfunction

		function void parse_byte(logic [7:0] c, int unsigned at);
			logic [7:0] lc;
			string      scheme_txt;
			scheme_txt = "coap";
			lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
			if (phase == PH_START) begin
				if (c == "/") begin
					open_path(at);
					return;
				end
				phase = PH_SCHEME;
				idx = 0;
			end
			case (phase)
				PH_SCHEME: begin
					if (idx < 4 && lc == scheme_txt[idx]) begin
						idx++;
						if (idx == 4) begin
							phase = PH_SOPT;
							idx = 0;
						end
					end else begin
						err = ST_SCHEME;
					end
				end
				PH_SOPT: begin
					phase = PH_SEP;
					idx = 0;
					if (c == "s")
						sec = 1;
					else
						match_sep(c);
				end
				PH_SEP: match_sep(c);
				PH_HOSTFIRST: begin
					if (c == "[") begin
						phase = PH_BRACKET;
						h_start = at + 1;
						h_cnt = 0;
					end else if (c == ":" || c == "/" || c == "?") begin
						err = ST_HOST;
					end else begin
						phase = PH_HOST;
						h_start = at;
						h_cnt = 1;
					end
				end
				PH_HOST: begin
					if (c == ":" || c == "/" || c == "?")
						after_host(c, at);
					else
						h_cnt++;
				end
				PH_BRACKET: begin
					if (c == "]") begin
						if (h_cnt == 0)
							err = ST_HOST;
						else
							phase = PH_AFTERHOST;
					end else begin
						h_cnt++;
					end
				end
				PH_AFTERHOST: after_host(c, at);
				PH_PORT: begin
					if (c >= "0" && c <= "9") begin
						// saturate one past the legal range
						acc = acc * 10 + (c - "0");
						if (acc > 65536)
							acc = 65536;
						seen = 1;
					end else if (acc > 65535) begin
						err = ST_RANGE;
					end else if (c == "/") begin
						open_path(at);
					end else if (c == "?") begin
						open_query(at);
					end else begin
						err = ST_TRAIL;
					end
				end
				PH_PATH: begin
					if (c == "?")
						open_query(at);
					else
						p_cnt++;
				end
				PH_QUERY: q_cnt++;
				default: err = ST_SCHEME;
			endcase
		endfunction

		function void take_byte(logic [7:0] c, logic fin);
			status_t st;
			result_t r;
			bytes++;
			if (pos >= MAX_URI_BYTES) begin
				err = ST_TOOLONG;
			end else begin
				pos++;
				if (err == ST_OK)
					parse_byte(c, pos - 1);
			end
			if (!fin)
				return;
			uris++;
			st = err;
			if (st == ST_OK) begin
				case (phase)
					PH_START, PH_SCHEME: st = ST_SCHEME;
					PH_SOPT, PH_SEP: st = ST_SEP;
					PH_HOSTFIRST, PH_BRACKET: st = ST_HOST;
					PH_PORT: st = (acc > 65535) ? ST_RANGE : ST_OK;
					default: st = ST_OK;
				endcase
			end
			r = '0;
			r.status = st;
			if (st == ST_OK) begin
				r.secure = sec;
				r.port = seen ? acc[PORT_W-1:0] : (sec ? secure_port : plain_port);
				if (h_cnt != 0) begin
					r.host_offset = h_start[OFF_W-1:0];
					r.host_length = h_cnt[LEN_W-1:0];
				end
				if (p_cnt != 0) begin
					r.path_offset = p_start[OFF_W-1:0];
					r.path_length = p_cnt[LEN_W-1:0];
				end
				if (q_cnt != 0) begin
					r.query_offset = q_start[OFF_W-1:0];
					r.query_length = q_cnt[LEN_W-1:0];
				end
			end
			split_due.push_back(r);
			restart();
		endfunction

		function void cmp(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] beat);
			result_t got, want;
			got = result_t'(beat[RES_W-1:0]);
			if (split_due.size() == 0) begin
				$error("result beat %h with no URI pending", beat);
				errors++;
				return;
			end
			want = split_due.pop_front();
			checked++;
			cmp("status", want.status, got.status);
			cmp("secure", want.secure, got.secure);
			cmp("port", want.port, got.port);
			cmp("host_offset", want.host_offset, got.host_offset);
			cmp("host_length", want.host_length, got.host_length);
			cmp("path_offset", want.path_offset, got.path_offset);
			cmp("path_length", want.path_length, got.path_length);
			cmp("query_offset", want.query_offset, got.query_offset);
			cmp("query_length", want.query_length, got.query_length);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'h00;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [PORT_W-1:0]     cfg_data = '0;

	uri_split_board board = new();
	logic [7:0]     uri_buf[$];
	int unsigned    gap_pct = 0;
	int unsigned    stall_pct = 0;

	string dir_uris[$] = '{
		"coap://host", "coaps://h:5683/p?q", "COAP://[::1]:65535/a/b?x=1",
		"coap://h:65536", "coap://h:99999999/x", "/path?query", "/", "x", "?",
		"coa", "coap:/", "coap", "coaps", "coapS://h", "coap://", "coap://[",
		"coap://[]", "coap:///p", "coap://[ab]x", "coap://h:12x", "coap://h?q",
		"coap://h:?", "coap://h:", "coap://h/", "coap://h:0", "CoApS://[ab]"
	};

	coap_uri_splitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.take_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (cfg_valid && cfg_ready)
				board.set_reg(cfg_reg_t'(cfg_index), cfg_data);
		end
	end

	function automatic logic [7:0] pick_byte(string excl);
		logic [7:0] b;
		bit         hit;
		do begin
			b = 8'($urandom_range(255));
			hit = 0;
			foreach (excl[i])
				if (excl[i] == b)
					hit = 1;
		end while (hit);
		return b;
	endfunction

	function automatic void add_text(string s);
		foreach (s[i])
			uri_buf.push_back(s[i]);
	endfunction

	function automatic void add_chars(int unsigned n, string excl);
		repeat (n)
			uri_buf.push_back(pick_byte(excl));
	endfunction

	function automatic void build_uri();
		int unsigned form, n;
		string       scheme_txt;
		scheme_txt = "coap";
		uri_buf.delete();
		form = $urandom_range(99);
		if (form < 8) begin
			// pure noise
			repeat ($urandom_range(1, 10))
				uri_buf.push_back(8'($urandom_range(255)));
			return;
		end
		if (form < 25) begin
			add_text("/");
			add_chars($urandom_range(0, 6), "?");
		end else begin
			foreach (scheme_txt[i])
				uri_buf.push_back($urandom_range(1) ? scheme_txt[i] - 8'd32 : scheme_txt[i]);
			n = $urandom_range(99);
			if (n < 40)
				add_text("s");
			else if (n < 45)
				add_text("S");
			add_text("://");
			if ($urandom_range(3) == 0) begin
				add_text("[");
				add_chars($urandom_range(0, 6), "]");
				add_text("]");
			end else begin
				add_chars(1, ":/?[");
				add_chars($urandom_range(0, 7), ":/?");
			end
			if ($urandom_range(99) < 40) begin
				add_text(":");
				case ($urandom_range(3))
					0: ;
					1, 2: add_text($sformatf("%0d", $urandom_range(65535)));
					default: repeat ($urandom_range(1, 9))
						uri_buf.push_back(8'h30 + 8'($urandom_range(9)));
				endcase
			end
			if ($urandom_range(99) < 60) begin
				add_text("/");
				add_chars($urandom_range(0, 6), "?");
			end
		end
		if ($urandom_range(99) < 40) begin
			add_text("?");
			repeat ($urandom_range(0, 6))
				uri_buf.push_back(8'($urandom_range(255)));
		end
		// break some of the sequences: cut short or corrupt one byte
		n = $urandom_range(99);
		if (n < 8 && uri_buf.size() > 1)
			uri_buf = uri_buf[0:$urandom_range(0, uri_buf.size() - 2)];
		else if (n < 15)
			uri_buf[$urandom_range(0, uri_buf.size() - 1)] = 8'($urandom_range(255));
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_uri();
		foreach (uri_buf[i])
			send_beat(uri_buf[i], i == uri_buf.size() - 1);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [PORT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_ports(input logic [PORT_W-1:0] plain, input logic [PORT_W-1:0] secure);
		write_reg(REG_DEFAULT_PORT, plain);
		write_reg(REG_SECURE_DEFAULT_PORT, secure);
		cfg_valid <= 1'b0;
	endtask

	// drop valid, then wait out every pending result plus the pipeline
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.split_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned sent;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults still in place here
		foreach (dir_uris[k]) begin
			uri_buf.delete();
			add_text(dir_uris[k]);
			send_uri();
		end

		for (int p = 0; p < 4; p++) begin
			settle();
			case (p)
				0: begin gap_pct = 0;  stall_pct = 0;  load_ports(16'd0, 16'hffff); end
				1: begin gap_pct = 69; stall_pct = 0;  load_ports(16'hffff, 16'd0); end
				2: begin
					gap_pct = 0;
					stall_pct = 69;
					load_ports(16'($urandom_range(65535)), 16'($urandom_range(65535)));
				end
				default: begin
					gap_pct = 34;
					stall_pct = 34;
					load_ports(16'($urandom_range(65535)), 16'($urandom_range(65535)));
				end
			endcase
			sent = 0;
			while (sent < 125) begin
				build_uri();
				send_uri();
				sent += uri_buf.size();
			end
		end
		settle();

		if (board.split_due.size() != 0)
			$error("%0d results never arrived", board.split_due.size());
		$display("covered %0d URIs in %0d bytes, %0d results checked;", board.uris,
			board.bytes, board.checked);
		$display("default ports at extremes and random values, four flow-control mixes");
		if (board.errors == 0 && board.split_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
rtl/cus_pkg.sv
rtl/cus_in_reg.sv
rtl/cus_parser.sv
rtl/cus_out_reg.sv
rtl/coap_uri_splitter.sv
dv/coap_uri_splitter_tb.sv
